@@ hw/rtl/fibt_pkg.sv @@
// shared constants, codes and types of the four-index basis transform
`timescale 1ns / 1ps

package fibt_pkg;

  // basis size and derived widths
  localparam int MAX_ORB = 8;
  localparam int OW      = $clog2(MAX_ORB);
  localparam int FW      = 4;
  localparam int SC_W    = $clog2(MAX_ORB + 1);
  localparam int TE_AW   = 4 * OW;
  localparam int MAT_AW  = 2 * OW;
  localparam int TE_DEPTH  = MAX_ORB ** 4;
  localparam int MAT_DEPTH = MAX_ORB ** 2;

  // fixed point format
  localparam int VW    = 48;
  localparam int FRAC  = 32;
  localparam int ACC_W = VW + 4;

  // item modes
  localparam logic [1:0] MODE_INT   = 2'd0;
  localparam logic [1:0] MODE_COEF  = 2'd1;
  localparam logic [1:0] MODE_OVLP  = 2'd2;
  localparam logic [1:0] MODE_QUERY = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TWO  = 2'd0;
  localparam logic [1:0] KIND_ONE  = 2'd1;
  localparam logic [1:0] KIND_SCAL = 2'd2;
  localparam logic [1:0] KIND_ACK  = 2'd3;

  typedef logic signed [VW-1:0]    val_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [FW-1:0]           fidx_t;

endpackage

@@ hw/rtl/fibt_if.sv @@
// channel interfaces of the four-index basis transform
`timescale 1ns / 1ps

interface fibt_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  fibt_pkg::fidx_t     index_first;
  fibt_pkg::fidx_t     index_second;
  fibt_pkg::fidx_t     index_third;
  fibt_pkg::fidx_t     index_fourth;
  fibt_pkg::val_t      load_value;

  modport source (output valid, mode, index_first, index_second, index_third, index_fourth,
                  load_value, input ready);
  modport sink (input valid, mode, index_first, index_second, index_third, index_fourth,
                load_value, output ready);
endinterface

interface fibt_out_if;
  logic                valid;
  logic                ready;
  fibt_pkg::val_t      result_value;
  logic [1:0]          result_kind;

  modport source (output valid, result_value, result_kind, input ready);
  modport sink (input valid, result_value, result_kind, output ready);
endinterface

interface fibt_cfg_if;
  logic                valid;
  logic                ready;
  logic [3:0]          orbital_count;

  modport source (output valid, orbital_count, input ready);
  modport sink (input valid, orbital_count, output ready);
endinterface

@@ hw/rtl/four_index_basis_transform.sv @@
// four-index basis transform: integral stores, C and S matrices, transformed-value queries
// loads of C or S in range are written as they are taken, then acknowledged; an integral load
// first writes its symmetric key permutations. a query first builds its U and V vectors (4*N*N
// products for two-electron, 2*N*N for one-electron), then contracts through the shared
// multiplier: two-electron N^4+N^3+N^2+N products.
// after reset a clearing pass zeroes the stores before any item is taken.
`timescale 1ns / 1ps

module four_index_basis_transform (
  input  logic       clk,
  input  logic       rst_n,
  fibt_in_if.sink    in_ch,
  fibt_out_if.source out_ch,
  fibt_cfg_if.sink   cfg_ch
);

  localparam int OW      = fibt_pkg::OW;
  localparam int FW      = fibt_pkg::FW;
  localparam int VW      = fibt_pkg::VW;
  localparam int ACC_W   = fibt_pkg::ACC_W;
  localparam int MAX_ORB = fibt_pkg::MAX_ORB;
  localparam int TE_AW   = fibt_pkg::TE_AW;
  localparam int NPERM   = 8;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PERM  = 4'd2;
  localparam logic [3:0] S_VRD   = 4'd3;
  localparam logic [3:0] S_VMUL  = 4'd4;
  localparam logic [3:0] S_VWAIT = 4'd5;
  localparam logic [3:0] S_LEAF  = 4'd6;
  localparam logic [3:0] S_LMUL  = 4'd7;
  localparam logic [3:0] S_MWAIT = 4'd8;
  localparam logic [3:0] S_STEP  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  function automatic logic in_range(input fibt_pkg::fidx_t x, input logic [FW:0] n);
    return (x != '0) && ({1'b0, x} <= n);
  endfunction

  function automatic logic [OW-1:0] idx0(input fibt_pkg::fidx_t x);
    fibt_pkg::fidx_t t;
    t = x - FW'(1);
    return t[OW-1:0];
  endfunction

  function automatic fibt_pkg::val_t sat48(input fibt_pkg::acc_t a);
    if (a[ACC_W-1:VW-1] == '0 || a[ACC_W-1:VW-1] == '1) begin
      return a[VW-1:0];
    end
    return a[ACC_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  endfunction

  // control and latched item
  logic [3:0]                    state_r, state_nxt;
  logic [3:0]                    oc_r;
  logic [fibt_pkg::TE_AW-1:0]    clr_r;
  fibt_pkg::fidx_t               p_r, q_r, r_r, s_r;
  fibt_pkg::val_t                ld_r;
  logic [2:0]                    perm_r;
  logic                          twoe_r;
  logic [1:0]                    vv_r, nvlast_r, lv_r, last_r;
  logic [OW-1:0]                 e_r, rr_r;
  logic [OW-1:0]                 idx_r [4];
  fibt_pkg::acc_t                vacc_r;
  fibt_pkg::acc_t                acc_r [4];
  fibt_pkg::val_t                vec_r [4][MAX_ORB];
  fibt_pkg::val_t                scalar_r [MAX_ORB+1];
  fibt_pkg::val_t                res_r;
  logic [1:0]                    kind_r;
  logic                          out_valid_r;
  fibt_pkg::val_t                outv_r;
  logic [1:0]                    outk_r;

  // memories
  fibt_pkg::val_t te_mem [fibt_pkg::TE_DEPTH];
  fibt_pkg::val_t oe_mem [fibt_pkg::MAT_DEPTH];
  fibt_pkg::val_t c_mem  [fibt_pkg::MAT_DEPTH];
  fibt_pkg::val_t s_mem  [fibt_pkg::MAT_DEPTH];
  fibt_pkg::val_t te_rd_r, oe_rd_r, c_rd_r, s_rd_r;

  logic                       te_we, oe_we, c_we, s_we;
  logic [fibt_pkg::TE_AW-1:0]  te_wa, te_ra;
  logic [fibt_pkg::MAT_AW-1:0] oe_wa, oe_ra, mat_wa, c_ra, s_ra;
  fibt_pkg::val_t             te_wd, oe_wd, mat_wd;

  logic                  accept_in;
  logic [FW:0]           n_eff, nm1_w;
  logic [OW-1:0]         nm1;
  logic                  q_two, q_two_ok, q_one_ok, mat_ok;
  fibt_pkg::fidx_t       kw, kx, ky, kz;
  logic                  key_te, key_oe, key_sc;
  logic [OW-1:0]         tidx;
  logic                  vis_u;
  logic                  v_all_done, idx_end;
  logic [1:0]            vr_lvl;
  fibt_pkg::val_t        vec_rd;
  fibt_pkg::acc_t        vsum;
  logic                  mul_start, mul_done;
  fibt_pkg::val_t        mul_x, mul_y, mul_p;

  assign accept_in    = in_ch.valid & in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // effective orbital count
  always_comb begin
    if (oc_r == '0) begin
      n_eff = (FW+1)'(1);
    end else if ({1'b0, oc_r} > (FW+1)'(MAX_ORB)) begin
      n_eff = (FW+1)'(MAX_ORB);
    end else begin
      n_eff = {1'b0, oc_r};
    end
    nm1_w = n_eff - (FW+1)'(1);
    nm1   = nm1_w[OW-1:0];
  end

  // query classification on the incoming item
  always_comb begin
    q_two    = (in_ch.index_third != '0) || (in_ch.index_fourth != '0);
    q_two_ok = in_range(in_ch.index_first, n_eff) && in_range(in_ch.index_second, n_eff) &&
               in_range(in_ch.index_third, n_eff) && in_range(in_ch.index_fourth, n_eff);
    q_one_ok = in_range(in_ch.index_first, n_eff) && in_range(in_ch.index_second, n_eff);
    mat_ok   = ({1'b0, in_ch.index_first} < (FW+1)'(MAX_ORB)) &&
               ({1'b0, in_ch.index_second} < (FW+1)'(MAX_ORB));
  end

  // symmetric key permutations of an integral load
  always_comb begin
    case (perm_r)
      3'd0:    begin kw = p_r; kx = q_r; ky = r_r; kz = s_r; end
      3'd1:    begin kw = r_r; kx = s_r; ky = p_r; kz = q_r; end
      3'd2:    begin kw = q_r; kx = p_r; ky = s_r; kz = r_r; end
      3'd3:    begin kw = s_r; kx = r_r; ky = q_r; kz = p_r; end
      3'd4:    begin kw = q_r; kx = p_r; ky = r_r; kz = s_r; end
      3'd5:    begin kw = s_r; kx = r_r; ky = p_r; kz = q_r; end
      3'd6:    begin kw = p_r; kx = q_r; ky = s_r; kz = r_r; end
      default: begin kw = r_r; kx = s_r; ky = q_r; kz = p_r; end
    endcase
    key_te = in_range(kw, (FW+1)'(MAX_ORB)) && in_range(kx, (FW+1)'(MAX_ORB)) &&
             in_range(ky, (FW+1)'(MAX_ORB)) && in_range(kz, (FW+1)'(MAX_ORB));
    key_oe = in_range(kw, (FW+1)'(MAX_ORB)) && in_range(kx, (FW+1)'(MAX_ORB)) &&
             (ky == '0) && (kz == '0);
    key_sc = (kx == '0) && (ky == '0) && (kz == '0) && ({1'b0, kw} <= (FW+1)'(MAX_ORB));
  end

  // memory write ports: clearing pass or loads
  always_comb begin
    te_we  = (state_r == S_CLEAR) || (state_r == S_PERM && key_te);
    te_wa  = (state_r == S_CLEAR) ? clr_r : {idx0(kw), idx0(kx), idx0(ky), idx0(kz)};
    te_wd  = (state_r == S_CLEAR) ? '0 : ld_r;
    oe_we  = (state_r == S_CLEAR) || (state_r == S_PERM && key_oe);
    oe_wa  = (state_r == S_CLEAR) ? clr_r[fibt_pkg::MAT_AW-1:0] : {idx0(kw), idx0(kx)};
    oe_wd  = (state_r == S_CLEAR) ? '0 : ld_r;
    c_we   = (state_r == S_CLEAR) || (accept_in && in_ch.mode == fibt_pkg::MODE_COEF && mat_ok);
    s_we   = (state_r == S_CLEAR) || (accept_in && in_ch.mode == fibt_pkg::MODE_OVLP && mat_ok);
    mat_wa = (state_r == S_CLEAR) ? clr_r[fibt_pkg::MAT_AW-1:0] :
             {in_ch.index_first[OW-1:0], in_ch.index_second[OW-1:0]};
    mat_wd = (state_r == S_CLEAR) ? '0 : in_ch.load_value;
  end

  // read addresses for vector build and contraction
  always_comb begin
    case (vv_r)
      2'd0:    tidx = idx0(p_r);
      2'd1:    tidx = idx0(q_r);
      2'd2:    tidx = idx0(r_r);
      default: tidx = idx0(s_r);
    endcase
    vis_u = twoe_r ? (vv_r < 2'd2) : (vv_r == 2'd0);
    s_ra  = vis_u ? {rr_r, tidx} : {tidx, rr_r};
    c_ra  = {rr_r, e_r};
    te_ra = {idx_r[0], idx_r[1], idx_r[2], idx_r[3]};
    oe_ra = {idx_r[0], idx_r[1]};
  end

  always_ff @(posedge clk) begin
    if (te_we) te_mem[te_wa] <= te_wd;
    te_rd_r <= te_mem[te_ra];
  end

  always_ff @(posedge clk) begin
    if (oe_we) oe_mem[oe_wa] <= oe_wd;
    oe_rd_r <= oe_mem[oe_ra];
  end

  always_ff @(posedge clk) begin
    if (c_we) c_mem[mat_wa] <= mat_wd;
    c_rd_r <= c_mem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) s_mem[mat_wa] <= mat_wd;
    s_rd_r <= s_mem[s_ra];
  end

  // multiplier operands
  always_comb begin
    vr_lvl     = (state_r == S_LMUL) ? last_r : lv_r - 2'd1;
    vec_rd     = vec_r[vr_lvl][idx_r[vr_lvl]];
    idx_end    = (idx_r[lv_r] == nm1);
    v_all_done = (rr_r == nm1) && (e_r == nm1) && (vv_r == nvlast_r);
    vsum       = vacc_r + ACC_W'(mul_p);
    mul_start  = (state_r == S_VMUL) || (state_r == S_LMUL) ||
                 (state_r == S_STEP && idx_end && lv_r != 2'd0);
    if (state_r == S_VMUL) begin
      mul_x = s_rd_r;
      mul_y = c_rd_r;
    end else if (state_r == S_LMUL) begin
      mul_x = vec_rd;
      mul_y = twoe_r ? te_rd_r : oe_rd_r;
    end else begin
      mul_x = vec_rd;
      mul_y = sat48(acc_r[lv_r]);
    end
  end

  fibt_qmul u_qmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .p     (mul_p)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept_in) begin
          case (in_ch.mode)
            fibt_pkg::MODE_INT:  state_nxt = S_PERM;
            fibt_pkg::MODE_COEF: state_nxt = S_FIN;
            fibt_pkg::MODE_OVLP: state_nxt = S_FIN;
            default: begin
              if (q_two) begin
                state_nxt = q_two_ok ? S_VRD : S_FIN;
              end else if (in_ch.index_second != '0) begin
                state_nxt = q_one_ok ? S_VRD : S_FIN;
              end else begin
                state_nxt = S_FIN;
              end
            end
          endcase
        end
      end
      S_PERM:  if (perm_r == 3'(NPERM - 1)) state_nxt = S_FIN;
      S_VRD:   state_nxt = S_VMUL;
      S_VMUL:  state_nxt = S_VWAIT;
      S_VWAIT: if (mul_done) state_nxt = v_all_done ? S_LEAF : S_VRD;
      S_LEAF:  state_nxt = S_LMUL;
      S_LMUL:  state_nxt = S_MWAIT;
      S_MWAIT: if (mul_done) state_nxt = S_STEP;
      S_STEP: begin
        if (!idx_end) state_nxt = S_LEAF;
        else if (lv_r == 2'd0) state_nxt = S_FIN;
        else state_nxt = S_MWAIT;
      end
      S_FIN:   if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers, scalar store and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      oc_r        <= 4'd6;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= MAX_ORB; i++) scalar_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + TE_AW'(1);
      if (cfg_ch.valid && cfg_ch.ready) oc_r <= cfg_ch.orbital_count;
      if (state_r == S_PERM && key_sc) scalar_r[fibt_pkg::SC_W'(kw)] <= ld_r;
      // output register
      if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
      outv_r <= res_r;
      outk_r <= kind_r;
    end
    case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          p_r    <= in_ch.index_first;
          q_r    <= in_ch.index_second;
          r_r    <= in_ch.index_third;
          s_r    <= in_ch.index_fourth;
          ld_r   <= in_ch.load_value;
          perm_r <= '0;
          vv_r   <= '0;
          e_r    <= '0;
          rr_r   <= '0;
          vacc_r <= '0;
          for (int i = 0; i < 4; i++) begin
            idx_r[i] <= '0;
            acc_r[i] <= '0;
          end
          res_r  <= '0;
          kind_r <= fibt_pkg::KIND_ACK;
          twoe_r <= q_two;
          if (q_two) begin
            nvlast_r <= 2'd3;
            last_r   <= 2'd3;
            lv_r     <= 2'd3;
          end else begin
            nvlast_r <= 2'd1;
            last_r   <= 2'd1;
            lv_r     <= 2'd1;
          end
          if (in_ch.mode == fibt_pkg::MODE_QUERY) begin
            if (q_two) begin
              kind_r <= fibt_pkg::KIND_TWO;
            end else if (in_ch.index_second != '0) begin
              kind_r <= fibt_pkg::KIND_ONE;
            end else begin
              kind_r <= fibt_pkg::KIND_SCAL;
              if ({1'b0, in_ch.index_first} <= n_eff) begin
                res_r <= scalar_r[fibt_pkg::SC_W'(in_ch.index_first)];
              end
            end
          end
        end
      end
      S_PERM: perm_r <= perm_r + 3'd1;
      S_VWAIT: begin
        if (mul_done) begin
          if (rr_r != nm1) begin
            vacc_r <= vsum;
            rr_r   <= rr_r + OW'(1);
          end else begin
            vec_r[vv_r][e_r] <= sat48(vsum);
            vacc_r <= '0;
            rr_r   <= '0;
            if (e_r != nm1) begin
              e_r <= e_r + OW'(1);
            end else begin
              e_r  <= '0;
              vv_r <= vv_r + 2'd1;
            end
          end
        end
      end
      S_MWAIT: if (mul_done) acc_r[lv_r] <= acc_r[lv_r] + ACC_W'(mul_p);
      S_STEP: begin
        if (!idx_end) begin
          idx_r[lv_r] <= idx_r[lv_r] + OW'(1);
          lv_r        <= last_r;
        end else begin
          idx_r[lv_r] <= '0;
          if (lv_r == 2'd0) begin
            res_r <= sat48(acc_r[0]);
          end else begin
            acc_r[lv_r] <= '0;
            lv_r        <= lv_r - 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = outv_r;
  assign out_ch.result_kind  = outk_r;

`ifndef SYNTH
  // multiplier results only arrive while the sequencer waits for them
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_VWAIT || state_r == S_MWAIT))
    else $error("multiplier result outside a wait state");

  // a new result only comes from the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised without finishing an item");

  // leaf reads always happen at the innermost level
  a_leaf_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEAF) |-> (lv_r == last_r))
    else $error("leaf read at an outer level");

  // the clearing pass only hands over to idle
  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> (state_r == S_CLEAR || state_r == S_IDLE))
    else $error("clearing pass left early");
`endif

endmodule

@@ hw/rtl/fibt_qmul.sv @@
// multi-cycle q32 multiplier with rounding and saturation, one 24x24 product a cycle
`timescale 1ns / 1ps

module fibt_qmul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  fibt_pkg::val_t x,
  input  fibt_pkg::val_t y,
  output logic           done,
  output fibt_pkg::val_t p
);

  localparam int VW   = fibt_pkg::VW;
  localparam int HW   = VW / 2;
  localparam int PW   = 2 * VW;
  localparam int MAGW = PW - fibt_pkg::FRAC;

  logic [VW-1:0]   ux_r;
  logic [VW-1:0]   uy_r;
  logic            neg_r;
  logic            run_r;
  logic [2:0]      cnt_r;
  logic [2*HW-1:0] pp_r;
  logic [1:0]      pp_sh_r;
  logic [PW-1:0]   prod_r;
  logic            done_r;
  fibt_pkg::val_t  p_r;

  logic [HW-1:0]   a_part;
  logic [HW-1:0]   b_part;
  logic [PW-1:0]   pp_shifted;
  logic [PW-1:0]   rsum;
  logic [MAGW-1:0] mag;
  logic [MAGW-1:0] lim;
  logic [VW-1:0]   mag_lo;
  fibt_pkg::val_t  res;

  // partial product selection
  always_comb begin
    a_part = cnt_r[0] ? ux_r[VW-1:HW] : ux_r[HW-1:0];
    b_part = cnt_r[1] ? uy_r[VW-1:HW] : uy_r[HW-1:0];
    case (pp_sh_r)
      2'd0:    pp_shifted = PW'(pp_r);
      2'd1:    pp_shifted = PW'(pp_r) << HW;
      default: pp_shifted = PW'(pp_r) << (2 * HW);
    endcase
  end

  // round half away from zero on the magnitude, then saturate
  always_comb begin
    rsum   = prod_r + (PW'(1) << (fibt_pkg::FRAC - 1));
    mag    = rsum[PW-1:fibt_pkg::FRAC];
    lim    = MAGW'(1) << (VW - 1);
    mag_lo = mag[VW-1:0];
    if (neg_r) begin
      res = (mag > lim) ? {1'b1, {(VW-1){1'b0}}} : -$signed(mag_lo);
    end else begin
      res = (mag >= lim) ? {1'b0, {(VW-1){1'b1}}} : $signed(mag_lo);
    end
  end

  // operand latch, product sequence and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ux_r   <= x[VW-1] ? VW'(-x) : VW'(x);
        uy_r   <= y[VW-1] ? VW'(-y) : VW'(y);
        neg_r  <= x[VW-1] ^ y[VW-1];
        prod_r <= '0;
        cnt_r  <= '0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r <= 3'd3) begin
          pp_r    <= a_part * b_part;
          pp_sh_r <= 2'(cnt_r[0]) + 2'(cnt_r[1]);
        end
        if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
          prod_r <= prod_r + pp_shifted;
        end
        if (cnt_r == 3'd5) begin
          p_r    <= res;
          done_r <= 1'b1;
          run_r  <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule
